@@ sv/riscv_subset_single_cycle_core_macros.svh @@
// Assertion helpers for the core's top-level RTL module.
`ifndef RISCV_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH
`define RISCV_SUBSET_SINGLE_CYCLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rsc_pkg.sv @@
package rsc_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_WORDS = 32;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int XLEN      = 32;

    typedef enum logic [1:0] {
        FMT_R = 2'd0,
        FMT_I = 2'd1,
        FMT_S = 2'd2,
        FMT_B = 2'd3
    } t_fmt;

    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_AND = 3'b111;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_SW  = 3'b010;

    localparam logic [1:0] ALUOP_ADD  = 2'd0;
    localparam logic [1:0] ALUOP_BR   = 2'd1;
    localparam logic [1:0] ALUOP_FUNC = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg_a;
        logic [4:0]  src_reg_b;
        logic [12:0] immediate;
    } t_instr;

    typedef struct packed {
        logic            branch;
        logic            mem_read;
        logic            mem_write;
        logic            mem_to_reg;
        logic            reg_write;
        logic [1:0]      alu_op;
        logic            alu_src;
        logic            branch_taken;
        logic [XLEN-1:0] write_value;
        logic [XLEN-1:0] next_pc;
        logic            address_error;
    } t_result;

    // Execute stage outcome handed back to the top level.
    typedef struct packed {
        logic              branch;
        logic              mem_read;
        logic              mem_write;
        logic              mem_to_reg;
        logic              reg_write;
        logic [1:0]        alu_op;
        logic              alu_src;
        logic              branch_taken;
        logic              address_error;
        logic              alu_wr;
        logic [XLEN-1:0]   alu_res;
        logic              mem_ok;
        logic [MEM_AW-1:0] mem_idx;
        logic [XLEN-1:0]   next_pc;
    } t_exec;

endpackage

@@ sv/rsc_in_if.sv @@
interface rsc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [12:0] immediate;

    modport source (
        output valid, action, funct3, funct7, dest_reg, src_reg_a, src_reg_b, immediate,
        input  ready
    );
    modport sink (
        input  valid, action, funct3, funct7, dest_reg, src_reg_a, src_reg_b, immediate,
        output ready
    );
endinterface

@@ sv/rsc_out_if.sv @@
interface rsc_out_if;
    logic               valid;
    logic               ready;
    logic               branch;
    logic               mem_read;
    logic               mem_write;
    logic               mem_to_reg;
    logic               reg_write;
    logic [1:0]         alu_op;
    logic               alu_src;
    logic               branch_taken;
    logic signed [31:0] write_value;
    logic signed [31:0] next_pc;
    logic               address_error;

    modport source (
        output valid, branch, mem_read, mem_write, mem_to_reg, reg_write, alu_op, alu_src,
               branch_taken, write_value, next_pc, address_error,
        input  ready
    );
    modport sink (
        input  valid, branch, mem_read, mem_write, mem_to_reg, reg_write, alu_op, alu_src,
               branch_taken, write_value, next_pc, address_error,
        output ready
    );
endinterface

@@ sv/rsc_ram.sv @@
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/rsc_exec.sv @@
module rsc_exec (
    input  rsc_pkg::t_instr          i_instr,
    input  logic [rsc_pkg::XLEN-1:0] i_opa,
    input  logic [rsc_pkg::XLEN-1:0] i_opb,
    input  logic [rsc_pkg::XLEN-1:0] i_pc,
    output rsc_pkg::t_exec           o_exec
);
    import rsc_pkg::*;

    logic [XLEN-1:0] imm32;
    logic [XLEN-1:0] sum;
    logic            in_range;
    logic            eq;
    t_exec           ex;

    always_comb begin
        imm32    = {{(XLEN-13){i_instr.immediate[12]}}, i_instr.immediate};
        sum      = i_opa + imm32;
        // word index is taken as signed: negative means out of range
        in_range = !sum[XLEN-1] && (sum < XLEN'(MEM_WORDS));
        eq       = (i_opa == i_opb);

        ex         = '0;
        ex.mem_idx = sum[MEM_AW-1:0];
        ex.next_pc = i_pc + XLEN'(4);

        case (t_fmt'(i_instr.action))
            FMT_R: begin
                ex.reg_write = 1'b1;
                ex.alu_op    = ALUOP_FUNC;
                case (i_instr.funct3)
                    F3_ADD: begin
                        ex.alu_res = (i_instr.funct7 != 7'd0) ? (i_opa - i_opb)
                                                              : (i_opa + i_opb);
                        ex.alu_wr  = 1'b1;
                    end
                    F3_AND: begin
                        ex.alu_res = i_opa & i_opb;
                        ex.alu_wr  = 1'b1;
                    end
                    F3_OR: begin
                        ex.alu_res = i_opa | i_opb;
                        ex.alu_wr  = 1'b1;
                    end
                    default: ;
                endcase
            end
            FMT_I: begin
                ex.reg_write = 1'b1;
                ex.alu_op    = ALUOP_ADD;
                ex.alu_src   = 1'b1;
                if (i_instr.funct3 == F3_ADD) begin
                    ex.alu_res = sum;
                    ex.alu_wr  = 1'b1;
                end else begin
                    ex.mem_read      = 1'b1;
                    ex.mem_to_reg    = 1'b1;
                    ex.mem_ok        = in_range;
                    ex.address_error = !in_range;
                end
            end
            FMT_S: begin
                if (i_instr.funct3 == F3_SW) begin
                    ex.mem_write     = 1'b1;
                    ex.alu_src       = 1'b1;
                    ex.mem_ok        = in_range;
                    ex.address_error = !in_range;
                end
            end
            FMT_B: begin
                ex.branch       = 1'b1;
                ex.alu_op       = ALUOP_BR;
                ex.branch_taken = (i_instr.funct3 == F3_ADD) ? eq : !eq;
                if (ex.branch_taken) begin
                    ex.next_pc = i_pc + imm32;
                end
            end
            default: ;
        endcase
    end

    assign o_exec = ex;
endmodule

@@ sv/riscv_subset_single_cycle_core.sv @@
// An accepted instruction beat passes through the input register (with the
// register-file read) and then the result register before its result beat appears.
// Throughput: one instruction per cycle unless o_out stalls; the register-file RAM
// read is issued at accept time and the previous instruction's write is forwarded around it.
// Reset (synchronous, active low) clears PC, data memory, register-file valid bits
// and all handshake state; no clearing pass is needed.
module riscv_subset_single_cycle_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rsc_in_if.sink    i_in,
    rsc_out_if.source o_out
);
    import rsc_pkg::*;
    `include "riscv_subset_single_cycle_core_macros.svh"

    logic                  r_s1_vld;
    t_instr                r_s1_instr;
    logic                  r_fwd_a;
    logic                  r_fwd_b;
    logic                  r_known_a;
    logic                  r_known_b;
    logic [XLEN-1:0]       r_fwd_data;
    logic [REG_COUNT-1:0]  r_reg_vld;
    logic [XLEN-1:0]       r_dmem [MEM_WORDS];
    logic [XLEN-1:0]       r_pc;
    logic                  r_out_vld;
    t_result               r_out;

    logic                  in_acc;
    logic                  s1_fire;
    logic [XLEN-1:0]       q_a;
    logic [XLEN-1:0]       q_b;
    logic [XLEN-1:0]       opa;
    logic [XLEN-1:0]       opb;
    t_exec                 ex;
    logic                  wr_reg;
    logic                  rf_we;
    logic [XLEN-1:0]       rf_wdata;
    logic [XLEN-1:0]       dmem_q;
    logic                  dmem_we;
    t_result               n_out;

    assign s1_fire    = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_fire;
    assign in_acc     = i_in.valid && i_in.ready;

    rsc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s1_instr.dest_reg),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (i_in.src_reg_a),
        .o_rdata (q_a)
    );

    rsc_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s1_instr.dest_reg),
        .i_wdata (rf_wdata),
        .i_re    (in_acc),
        .i_raddr (i_in.src_reg_b),
        .o_rdata (q_b)
    );

    // unwritten registers read as zero; a same-edge write is forwarded
    assign opa = r_fwd_a ? r_fwd_data : (r_known_a ? q_a : '0);
    assign opb = r_fwd_b ? r_fwd_data : (r_known_b ? q_b : '0);

    rsc_exec u_exec (
        .i_instr (r_s1_instr),
        .i_opa   (opa),
        .i_opb   (opb),
        .i_pc    (r_pc),
        .o_exec  (ex)
    );

    always_comb begin
        dmem_q   = r_dmem[ex.mem_idx];
        wr_reg   = (ex.alu_wr || (ex.mem_read && ex.mem_ok))
                   && (r_s1_instr.dest_reg != REG_AW'(0));
        rf_we    = s1_fire && wr_reg;
        rf_wdata = ex.alu_wr ? ex.alu_res : dmem_q;
        dmem_we  = s1_fire && ex.mem_write && ex.mem_ok;

        n_out.branch        = ex.branch;
        n_out.mem_read      = ex.mem_read;
        n_out.mem_write     = ex.mem_write;
        n_out.mem_to_reg    = ex.mem_to_reg;
        n_out.reg_write     = ex.reg_write;
        n_out.alu_op        = ex.alu_op;
        n_out.alu_src       = ex.alu_src;
        n_out.branch_taken  = ex.branch_taken;
        n_out.next_pc       = ex.next_pc;
        n_out.address_error = ex.address_error;
        if (wr_reg) begin
            n_out.write_value = rf_wdata;
        end else if (ex.mem_write && ex.mem_ok) begin
            n_out.write_value = opb;
        end else begin
            n_out.write_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_instr.action    <= i_in.action;
            r_s1_instr.funct3    <= i_in.funct3;
            r_s1_instr.funct7    <= i_in.funct7;
            r_s1_instr.dest_reg  <= i_in.dest_reg;
            r_s1_instr.src_reg_a <= i_in.src_reg_a;
            r_s1_instr.src_reg_b <= i_in.src_reg_b;
            r_s1_instr.immediate <= i_in.immediate;
            r_fwd_a    <= rf_we && (r_s1_instr.dest_reg == i_in.src_reg_a);
            r_fwd_b    <= rf_we && (r_s1_instr.dest_reg == i_in.src_reg_b);
            r_fwd_data <= rf_wdata;
            r_known_a  <= r_reg_vld[i_in.src_reg_a];
            r_known_b  <= r_reg_vld[i_in.src_reg_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (rf_we) begin
            r_reg_vld[r_s1_instr.dest_reg] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++) begin
                r_dmem[i] <= '0;
            end
        end else if (dmem_we) begin
            r_dmem[ex.mem_idx] <= opb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (s1_fire) begin
            r_pc <= ex.next_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.branch        = r_out.branch;
    assign o_out.mem_read      = r_out.mem_read;
    assign o_out.mem_write     = r_out.mem_write;
    assign o_out.mem_to_reg    = r_out.mem_to_reg;
    assign o_out.reg_write     = r_out.reg_write;
    assign o_out.alu_op        = r_out.alu_op;
    assign o_out.alu_src       = r_out.alu_src;
    assign o_out.branch_taken  = r_out.branch_taken;
    assign o_out.write_value   = $signed(r_out.write_value);
    assign o_out.next_pc       = $signed(r_out.next_pc);
    assign o_out.address_error = r_out.address_error;

    `RSC_ASSERT_NOW(a_x0_never_written, i_clk, i_rst_n, 1'b1, !r_reg_vld[0], "x0 marked written")
    `RSC_ASSERT_NOW(a_err_no_write, i_clk, i_rst_n, r_out_vld && r_out.address_error,
                    r_out.write_value == '0 && (r_out.mem_read || r_out.mem_write),
                    "address error with a write or on a non-memory op")
    `RSC_ASSERT_NOW(a_taken_is_branch, i_clk, i_rst_n, r_out_vld && r_out.branch_taken,
                    r_out.branch, "taken flag outside a branch")
    `RSC_ASSERT_NOW(a_stall_only_busy, i_clk, i_rst_n, !i_in.ready,
                    r_s1_vld && r_out_vld, "input stalled with a free stage")
    `RSC_ASSERT_NEXT(a_pc_step, i_clk, i_rst_n, s1_fire && !ex.branch_taken,
                     r_pc == $past(r_pc) + XLEN'(4), "PC did not advance by four")
endmodule
